// ===== sv/cnhs_pkg.sv =====
`timescale 1ns / 1ps

package cnhs_pkg;

   // Opcodes of an input beat
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_PACKET = 2'd2;

   // Received packet kinds
   localparam logic [1:0] RX_CON   = 2'd0;
   localparam logic [1:0] RX_SYN   = 2'd1;
   localparam logic [1:0] RX_ACK   = 2'd2;

   // Packets to send
   localparam logic [1:0] PKT_NONE = 2'd0;
   localparam logic [1:0] PKT_CON  = 2'd1;
   localparam logic [1:0] PKT_SYN  = 2'd2;
   localparam logic [1:0] PKT_ACK  = 2'd3;

   // Outcome events
   localparam logic [1:0] OUT_NONE      = 2'd0;
   localparam logic [1:0] OUT_CONNECTED = 2'd1;
   localparam logic [1:0] OUT_FAILED    = 2'd2;

   // Link phases
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_WAIT_SYN  = 2'd1;
   localparam logic [1:0] PH_WAIT_ACK  = 2'd2;
   localparam logic [1:0] PH_CONNECTED = 2'd3;

   localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  packet_kind;
      logic [7:0]  retry_limit;
      logic [15:0] timeout_ticks;
   } item_type;

   typedef struct packed {
      logic [1:0] send_packet;
      logic [1:0] outcome;
      logic [1:0] link_state;
      logic       handled;
   } result_type;

   // Link state apart from the timer count, whose width is a parameter
   typedef struct packed {
      logic [1:0]  phase;
      logic        opener;
      logic [7:0]  retries;
      logic        running;
      logic [15:0] delay;
   } link_type;

endpackage

// ===== sv/connect_handshake_fsm.sv =====
`timescale 1ns / 1ps

// Connection setup handshake for one link, acting as opening or responding side.
// Each input beat (tick, start connect, or received packet) gives exactly one
// result beat: packet to send, connect event, link state after the beat, and
// whether a received packet was consumed. A beat is registered at the input,
// then resolved against the link state by one pass of logic as it moves into
// the result register, so the block takes one beat per cycle while the result
// channel is not stalled; the input register lets a new beat in while a result
// waits under stall. The retransmit timer is TIMER_BITS wide and loads the
// delay saturated to that width. csr_wr_data sets the responder's retransmit
// delay; write it only while no beat is in flight.
module connect_handshake_fsm #(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_packet_kind,
   input  logic [7:0]  req_retry_limit,
   input  logic [15:0] req_timeout_ticks,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_send_packet,
   output logic [1:0]  rsp_outcome,
   output logic [1:0]  rsp_link_state,
   output logic        rsp_handled,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // input register
   logic                 s1_valid_ff;
   cnhs_pkg::item_type   s1_item_ff;
   // result register
   logic                 rsp_valid_ff;
   cnhs_pkg::result_type rsp_result_ff;
   // link state
   cnhs_pkg::link_type    link_ff;
   logic [TIMER_BITS-1:0] timer_ff;

   cnhs_pkg::link_type    link_in;
   logic [TIMER_BITS-1:0] timer_in;
   cnhs_pkg::result_type  result_in;
   cnhs_pkg::item_type    req_item;

   logic out_free;
   logic advance;
   logic req_take;

   assign req_item.opcode        = req_opcode;
   assign req_item.packet_kind   = req_packet_kind;
   assign req_item.retry_limit   = req_retry_limit;
   assign req_item.timeout_ticks = req_timeout_ticks;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   cnhs_step #(
      .TIMER_BITS(TIMER_BITS)
   ) u_step (
      .item       (s1_item_ff),
      .link       (link_ff),
      .timer_count(timer_ff),
      .link_in    (link_in),
      .timer_in   (timer_in),
      .result     (result_in)
   );

   // handshake pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_result_ff <= result_in;
      end
   end

   // link state commits only when its beat moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.phase   <= cnhs_pkg::PH_IDLE;
         link_ff.opener  <= 1'b0;
         link_ff.retries <= 8'd0;
         link_ff.running <= 1'b0;
         link_ff.delay   <= cnhs_pkg::DEFAULT_TIMEOUT_RESET;
         timer_ff        <= '0;
      end else begin
         if (advance) begin
            link_ff  <= link_in;
            timer_ff <= timer_in;
         end
         if (csr_wr_en) begin
            // the responder follows the register; the opener keeps its own delay
            if (!link_ff.opener) begin
               link_ff.delay <= csr_wr_data;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_send_packet = rsp_result_ff.send_packet;
   assign rsp_outcome     = rsp_result_ff.outcome;
   assign rsp_link_state  = rsp_result_ff.link_state;
   assign rsp_handled     = rsp_result_ff.handled;

   // a failure always drops the link to idle
   a_fail_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == cnhs_pkg::OUT_FAILED)) |->
      (rsp_link_state == cnhs_pkg::PH_IDLE && rsp_send_packet == cnhs_pkg::PKT_NONE))
      else $error("failure event without idle link");

   // connecting is only ever answered with ACK
   a_conn_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == cnhs_pkg::OUT_CONNECTED)) |->
      (rsp_link_state == cnhs_pkg::PH_CONNECTED && rsp_send_packet == cnhs_pkg::PKT_ACK &&
       rsp_handled))
      else $error("connect event inconsistent");

   // any send leaves the timer running
   a_send_arms: assert property (@(posedge clock) disable iff (reset)
      (advance && (result_in.send_packet != cnhs_pkg::PKT_NONE)) |=> link_ff.running)
      else $error("send without timer armed");

   // a stalled result holds when no beat moves into it
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_ff)))
      else $error("stalled result lost");

   // the opener flag never clears once set
   a_opener_sticky: assert property (@(posedge clock) disable iff (reset)
      link_ff.opener |=> link_ff.opener)
      else $error("opener flag cleared");

endmodule

// ===== sv/cnhs_step.sv =====
`timescale 1ns / 1ps

// One handshake step: current link state and one item in, next state and result out.
module cnhs_step #(
   parameter int TIMER_BITS = 16
) (
   input  cnhs_pkg::item_type    item,
   input  cnhs_pkg::link_type    link,
   input  logic [TIMER_BITS-1:0] timer_count,
   output cnhs_pkg::link_type    link_in,
   output logic [TIMER_BITS-1:0] timer_in,
   output cnhs_pkg::result_type  result
);

   logic [15:0]           delay_next;
   logic [TIMER_BITS-1:0] arm_value;
   logic [TIMER_BITS-1:0] count_dec;
   logic                  waiting;

   // New delay takes effect before the CON of a start request is armed
   assign delay_next = (item.opcode == cnhs_pkg::OP_START) ? item.timeout_ticks : link.delay;

   generate
      if (TIMER_BITS >= 16) begin : g_wide
         assign arm_value = TIMER_BITS'(delay_next);
      end else begin : g_sat
         assign arm_value = (|delay_next[15:TIMER_BITS]) ? {TIMER_BITS{1'b1}}
                                                         : delay_next[TIMER_BITS-1:0];
      end
   endgenerate

   assign count_dec = (timer_count != '0) ? timer_count - 1'b1 : timer_count;
   assign waiting   = link.phase inside {cnhs_pkg::PH_WAIT_SYN, cnhs_pkg::PH_WAIT_ACK};

   always_comb begin
      link_in            = link;
      link_in.delay      = delay_next;
      timer_in           = timer_count;
      result.send_packet = cnhs_pkg::PKT_NONE;
      result.outcome     = cnhs_pkg::OUT_NONE;
      result.handled     = 1'b0;

      case (item.opcode)
         cnhs_pkg::OP_TICK: begin
            if (link.running) begin
               timer_in = count_dec;
               if ((count_dec == '0) && waiting) begin
                  if (link.opener && (link.retries != 8'd0)) begin
                     link_in.retries = link.retries - 8'd1;
                  end
                  if (link.opener && (link.retries == 8'd1)) begin
                     // retry budget used up
                     result.outcome  = cnhs_pkg::OUT_FAILED;
                     link_in.phase   = cnhs_pkg::PH_IDLE;
                     link_in.running = 1'b0;
                  end else begin
                     result.send_packet = (link.phase == cnhs_pkg::PH_WAIT_SYN) ?
                                          cnhs_pkg::PKT_CON : cnhs_pkg::PKT_SYN;
                     timer_in           = arm_value;
                     link_in.running    = 1'b1;
                  end
               end
            end
         end
         cnhs_pkg::OP_START: begin
            result.send_packet = cnhs_pkg::PKT_CON;
            timer_in           = arm_value;
            link_in.running    = 1'b1;
            link_in.phase      = cnhs_pkg::PH_WAIT_SYN;
            link_in.opener     = 1'b1;
            link_in.retries    = item.retry_limit;
         end
         cnhs_pkg::OP_PACKET: begin
            if (link.opener) begin
               if (item.packet_kind == cnhs_pkg::RX_SYN) begin
                  if (link.phase == cnhs_pkg::PH_WAIT_SYN) begin
                     link_in.phase  = cnhs_pkg::PH_CONNECTED;
                     result.outcome = cnhs_pkg::OUT_CONNECTED;
                  end
                  result.send_packet = cnhs_pkg::PKT_ACK;
                  timer_in           = arm_value;
                  link_in.running    = 1'b1;
                  result.handled     = 1'b1;
               end
            end else begin
               if (item.packet_kind == cnhs_pkg::RX_CON) begin
                  result.send_packet = cnhs_pkg::PKT_SYN;
                  timer_in           = arm_value;
                  link_in.running    = 1'b1;
                  if (link.phase == cnhs_pkg::PH_IDLE) begin
                     link_in.phase = cnhs_pkg::PH_WAIT_ACK;
                  end
                  result.handled = 1'b1;
               end else if (item.packet_kind == cnhs_pkg::RX_ACK) begin
                  // responder connects silently
                  if (link.phase == cnhs_pkg::PH_WAIT_ACK) begin
                     link_in.phase = cnhs_pkg::PH_CONNECTED;
                  end
                  result.handled = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      result.link_state = link_in.phase;
   end

endmodule
